// ===== src/tadsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tadsr_pkg
// Shared types and constants of the table-driven envelope player.
// ----------------------------------------------------------------------------
package tadsr_pkg;

    // level code width, 0 to 5 V
    localparam int LEVEL_BITS = 12;
    localparam int INDEX_BITS = 10;
    localparam int STEP_BITS  = 11;
    localparam int ATK_BITS   = 10;
    localparam int REL_BITS   = 10;
    localparam int LEN_BITS   = 11;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SUSTAIN_ENABLE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_LENGTH = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TABLE_LENGTH   = 2'd3;

    // request function codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // reset values of the configuration registers
    localparam logic [ATK_BITS-1:0] ATTACK_LENGTH_RST  = '0;
    localparam logic                SUSTAIN_ENABLE_RST = 1'b1;
    localparam logic [REL_BITS-1:0] RELEASE_LENGTH_RST = '0;
    localparam logic [LEN_BITS-1:0] TABLE_LENGTH_RST   = 11'd1024;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    // where the level of a tick comes from
    typedef enum logic [1:0] {
        SEL_HOLD = 2'd0,
        SEL_ZERO = 2'd1,
        SEL_MEM  = 2'd2
    } t_level_sel;

    // per-tick decision from the sequencer
    typedef struct packed {
        logic       rd_en;
        t_level_sel sel;
        t_phase     phase;
    } t_step_ctl;

    typedef struct packed {
        logic                  func;
        logic                  button;
        logic [INDEX_BITS-1:0] entry_index;
        logic [LEVEL_BITS-1:0] entry_level;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic [1:0]            phase;
    } t_out_item;

endpackage

// ===== src/table_adsr_envelope_player.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_adsr_envelope_player
// Plays an envelope (attack, sustain loop, release) from a loaded level table.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_ready, payload i_in): a request with
//   func = write stores entry_level at entry_index and gives no result; a
//   request with func = tick takes the button level, advances the envelope
//   and gives one result (level, phase) on o_out_valid / i_out_ready.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
//   while the block is idle; every write takes effect at once.
//   A tick result passes the read stage, then the output register. Throughput:
//   one request per cycle unless stalled; the table is one memory with one
//   write and one read port, and the sequencer reads at most once a tick.
//   Stall: a held result keeps its value; one more tick waits in the read
//   stage, after which o_in_ready drops until the receiver takes a result.
//   Reset: phase idle, step 0, held level 0, configuration at its defaults,
//   pipeline empty. The table is not cleared; read it only after writing.
//   TABLE_DEPTH must be a power of two, which the block does not enforce; addresses wrap modulo the depth.
// ----------------------------------------------------------------------------
module table_adsr_envelope_player #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  tadsr_pkg::t_in_item                  i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output tadsr_pkg::t_out_item                 o_out,
    input  logic                                 i_cfg_we,
    input  logic [tadsr_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [tadsr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import tadsr_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [ATK_BITS-1:0]   r_attack_length;
    logic                  r_sustain_enable;
    logic [REL_BITS-1:0]   r_release_length;
    logic [LEN_BITS-1:0]   r_table_length;

    logic                  in_take, tick_take, write_take, s1_adv;
    t_step_ctl             ctl;
    logic [ADDR_W-1:0]     rd_addr;
    logic [LEVEL_BITS-1:0] rd_data;

    logic                  r_s1_valid;
    t_level_sel            r_s1_sel;
    t_phase                r_s1_phase;
    logic [LEVEL_BITS-1:0] r_held, n_held;
    logic                  r_out_valid;
    t_out_item             r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_length  <= ATTACK_LENGTH_RST;
            r_sustain_enable <= SUSTAIN_ENABLE_RST;
            r_release_length <= RELEASE_LENGTH_RST;
            r_table_length   <= TABLE_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ATTACK_LENGTH:  r_attack_length  <= i_cfg_data[ATK_BITS-1:0];
                CFG_SUSTAIN_ENABLE: r_sustain_enable <= i_cfg_data[0];
                CFG_RELEASE_LENGTH: r_release_length <= i_cfg_data[REL_BITS-1:0];
                CFG_TABLE_LENGTH:   r_table_length   <= i_cfg_data[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // request handshake; the read stage moves on when the output slot frees
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || !r_out_valid || i_out_ready;
    assign in_take    = i_in_valid && o_in_ready;
    assign tick_take  = in_take && (i_in.func == FUNC_TICK);
    assign write_take = in_take && (i_in.func == FUNC_WRITE);

    tadsr_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_tick           (tick_take),
        .i_button         (i_in.button),
        .i_attack_length  (r_attack_length),
        .i_sustain_enable (r_sustain_enable),
        .i_release_length (r_release_length),
        .i_table_length   (r_table_length),
        .o_rd_addr        (rd_addr),
        .o_ctl            (ctl)
    );

    tadsr_table_mem #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (write_take),
        .i_waddr (ADDR_W'(i_in.entry_index)),
        .i_wdata (i_in.entry_level),
        .i_re    (tick_take && ctl.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // read stage: waits for the table data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take || s1_adv) begin
            r_s1_valid <= tick_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_take) begin
            r_s1_sel   <= ctl.sel;
            r_s1_phase <= ctl.phase;
        end
    end

    // level of this tick
    always_comb begin
        unique case (r_s1_sel)
            SEL_MEM:  n_held = rd_data;
            SEL_ZERO: n_held = '0;
            SEL_HOLD: n_held = r_held;
            default:  n_held = r_held;
        endcase
    end

    // held level and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_held      <= n_held;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.level <= n_held;
            r_out.phase <= r_s1_phase;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== src/tadsr_table_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tadsr_table_mem
// Envelope table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tadsr_table_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [ADDR_W-1:0]               i_waddr,
    input  logic [tadsr_pkg::LEVEL_BITS-1:0] i_wdata,
    input  logic                            i_re,
    input  logic [ADDR_W-1:0]               i_raddr,
    output logic [tadsr_pkg::LEVEL_BITS-1:0] o_rdata
);
    import tadsr_pkg::*;

    logic [LEVEL_BITS-1:0] r_mem [DEPTH];
    logic [LEVEL_BITS-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tadsr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tadsr_ctrl
// Envelope sequencer: phase and step counter, table address for each tick.
// ----------------------------------------------------------------------------
module tadsr_ctrl #(
    parameter int TABLE_DEPTH = 1024,
    parameter int ADDR_W      = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_tick,
    input  logic                             i_button,
    input  logic [tadsr_pkg::ATK_BITS-1:0]   i_attack_length,
    input  logic                             i_sustain_enable,
    input  logic [tadsr_pkg::REL_BITS-1:0]   i_release_length,
    input  logic [tadsr_pkg::LEN_BITS-1:0]   i_table_length,
    output logic [ADDR_W-1:0]                o_rd_addr,
    output tadsr_pkg::t_step_ctl             o_ctl
);
    import tadsr_pkg::*;

    // wide enough for the table depth and for the sustain wrap sum
    localparam int CW = (ADDR_W + 1 > 13) ? ADDR_W + 1 : 13;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    t_phase               r_phase, n_phase;
    logic [STEP_BITS-1:0] r_step,  n_step;
    logic [STEP_BITS-1:0] step_inc;
    logic [CW-1:0]        len_ext, len_eff, sus_span, atk_sum, rel_sum;
    logic                 sus_wrap;

    // effective table length, clamped to 1..depth
    always_comb begin
        len_ext = CW'(i_table_length);
        if (i_table_length == '0) begin
            len_eff = CW'(1);
        end else if (len_ext > DEPTH_C) begin
            len_eff = DEPTH_C;
        end else begin
            len_eff = len_ext;
        end
    end

    // address sums, wrap modulo the table depth through the low bits
    assign step_inc = r_step + STEP_BITS'(1);
    assign atk_sum  = CW'(i_attack_length) + CW'(r_step);
    assign rel_sum  = len_eff - CW'(i_release_length) - CW'(1) + CW'(r_step);
    assign sus_span = CW'(step_inc) + CW'(i_attack_length) + CW'(i_release_length) + CW'(1);
    assign sus_wrap = (sus_span >= len_eff);

    // next phase, step and level source
    always_comb begin
        n_phase      = r_phase;
        n_step       = r_step;
        o_ctl.rd_en  = 1'b0;
        o_ctl.sel    = SEL_HOLD;
        o_rd_addr    = ADDR_W'(r_step);
        unique case (r_phase)
            PH_IDLE: begin
                o_ctl.sel = SEL_ZERO;
                if (i_button) begin
                    n_phase = PH_ATTACK;
                    n_step  = '0;
                end
            end
            PH_ATTACK: begin
                if (!i_button) begin
                    n_phase = PH_RELEASE;
                    n_step  = '0;
                end else if (r_step < STEP_BITS'(i_attack_length)) begin
                    o_ctl.rd_en = 1'b1;
                    o_ctl.sel   = SEL_MEM;
                    n_step      = step_inc;
                end else begin
                    n_phase = PH_SUSTAIN;
                    n_step  = '0;
                end
            end
            PH_SUSTAIN: begin
                o_rd_addr = ADDR_W'(atk_sum);
                if (!i_button) begin
                    n_phase = PH_RELEASE;
                    n_step  = '0;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    o_ctl.sel   = SEL_MEM;
                    n_step      = sus_wrap ? '0 : step_inc;
                end
            end
            PH_RELEASE: begin
                o_rd_addr = ADDR_W'(rel_sum);
                if (!i_sustain_enable || (i_release_length == '0)
                        || (r_step >= STEP_BITS'(i_release_length))) begin
                    o_ctl.sel = SEL_ZERO;
                    n_phase   = PH_IDLE;
                    n_step    = '0;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    o_ctl.sel   = SEL_MEM;
                    n_step      = step_inc;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        o_ctl.phase = n_phase;
    end

    // phase and step registers advance on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_step  <= '0;
        end else if (i_tick) begin
            r_phase <= n_phase;
            r_step  <= n_step;
        end
    end

endmodule

// ===== src/tadsr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tadsr_checker
// Port-level checks of the envelope player, bound to the top level.
// ----------------------------------------------------------------------------
module tadsr_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_in_ready,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    input  tadsr_pkg::t_out_item                 o_out
);
    import tadsr_pkg::*;

    // reset empties the output slot
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // an idle result always carries level zero
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.phase == PH_IDLE) |-> (o_out.level == '0))
        else $error("idle result with nonzero level");

    // with the output slot empty, a request is always taken
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request blocked while output slot empty");

endmodule

bind table_adsr_envelope_player tadsr_checker u_tadsr_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the table-driven envelope player. Requests (table
// writes and button ticks) go in through a valid/ready channel with random
// gaps. Results are checked field by field against an in-bench envelope
// predictor. Settings of the four registers change between phases, extremes
// included, and table entries are always written before the envelope reads them.
// ----------------------------------------------------------------------------
module testbench;

    import tadsr_pkg::*;

    localparam int DEPTH         = 1024;
    localparam int IDLE_PCT      = 9;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 4000;
    localparam int ITEMS_TARGET  = 1900;
    localparam int MAX_PRINTS    = 100;
    localparam int STEP_MASK     = (1 << STEP_BITS) - 1;

    // clock, reset and block ports
    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_in_valid;
    logic         o_in_ready;
    t_in_item     i_in;
    logic         o_out_valid;
    logic         i_out_ready = 1'b0;
    t_out_item    o_out;
    logic         i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    // predictor state and its copy of the registers
    t_phase                env_phase = PH_IDLE;
    logic [STEP_BITS-1:0]  env_step  = '0;
    logic [LEVEL_BITS-1:0] env_level = '0;
    logic [ATK_BITS-1:0]   atk_len   = ATTACK_LENGTH_RST;
    logic                  sus_en    = SUSTAIN_ENABLE_RST;
    logic [REL_BITS-1:0]   rel_len   = RELEASE_LENGTH_RST;
    logic [LEN_BITS-1:0]   tbl_len   = TABLE_LENGTH_RST;
    logic [LEVEL_BITS-1:0] table_image   [DEPTH];
    bit                    entry_written [DEPTH];

    t_out_item expected_envelope [$];
    int        mismatch_count = 0;
    int        item_count     = 0;
    int        stall_cycles   = 0;
    bit        no_idle        = 1'b0;

    always #1 i_clk = ~i_clk;

    table_adsr_envelope_player #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // one envelope step; state moves only when commit is set, rd_addr is -1 without a read
    function automatic t_out_item envelope_tick(input logic pressed, input bit commit,
                                                output int rd_addr);
        t_phase                ph;
        logic [STEP_BITS-1:0]  step;
        logic [LEVEL_BITS-1:0] lvl;
        int                    eff_len;
        int                    region;
        int                    nxt;
        t_out_item             res;
        ph      = env_phase;
        step    = env_step;
        lvl     = env_level;
        rd_addr = -1;
        eff_len = (tbl_len == 0) ? 1 : ((int'(tbl_len) > DEPTH) ? DEPTH : int'(tbl_len));
        region  = eff_len - int'(rel_len) - 1;
        case (env_phase)
            PH_IDLE: begin
                lvl = '0;
                if (pressed) begin
                    ph   = PH_ATTACK;
                    step = '0;
                end
            end
            PH_ATTACK: begin
                if (!pressed) begin
                    ph   = PH_RELEASE;
                    step = '0;
                end else if (int'(env_step) < int'(atk_len)) begin
                    rd_addr = int'(env_step) & (DEPTH - 1);
                    step    = env_step + 1'b1;
                end else begin
                    ph   = PH_SUSTAIN;
                    step = '0;
                end
            end
            PH_SUSTAIN: begin
                if (!pressed) begin
                    ph   = PH_RELEASE;
                    step = '0;
                end else begin
                    rd_addr = (int'(atk_len) + int'(env_step)) & (DEPTH - 1);
                    nxt     = (int'(env_step) + 1) & STEP_MASK;
                    // loop back once the counter reaches the start of the tail
                    if (nxt + int'(atk_len) >= region) nxt = 0;
                    step = STEP_BITS'(nxt);
                end
            end
            default: begin
                if (!sus_en || rel_len == 0 || int'(env_step) >= int'(rel_len)) begin
                    lvl  = '0;
                    ph   = PH_IDLE;
                    step = '0;
                end else begin
                    // tail address wraps, also from below zero
                    rd_addr = (region + int'(env_step)) & (DEPTH - 1);
                    step    = env_step + 1'b1;
                end
            end
        endcase
        if (rd_addr >= 0) lvl = table_image[rd_addr];
        if (commit) begin
            env_phase = ph;
            env_step  = step;
            env_level = lvl;
        end
        res.level = lvl;
        res.phase = ph;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // send one request; keep valid high from one request to the next unless idling
    task automatic send_request(input t_in_item req);
        int addr;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (!o_in_ready);
        item_count++;
        if (req.func == FUNC_WRITE) begin
            table_image[req.entry_index]   = req.entry_level;
            entry_written[req.entry_index] = 1'b1;
        end else begin
            expected_envelope.push_back(envelope_tick(req.button, 1'b1, addr));
        end
    endtask

    task automatic write_entry(input int index, input int level);
        t_in_item req;
        req.func        = FUNC_WRITE;
        req.button      = 1'($urandom_range(1));
        req.entry_index = INDEX_BITS'(index);
        req.entry_level = LEVEL_BITS'(level);
        send_request(req);
    endtask

    // tick with a button level; an entry it would read gets written first
    task automatic play_tick(input logic pressed);
        int        addr;
        t_in_item  req;
        void'(envelope_tick(pressed, 1'b0, addr));
        if (addr >= 0 && !entry_written[addr]) write_entry(addr, $urandom_range(4095));
        req.func        = FUNC_TICK;
        req.button      = pressed;
        req.entry_index = INDEX_BITS'($urandom);
        req.entry_level = LEVEL_BITS'($urandom);
        send_request(req);
    endtask

    // press for some ticks, then let go for some ticks
    task automatic play_gesture(input int hold, input int fall);
        repeat (hold) play_tick(1'b1);
        repeat (fall) play_tick(1'b0);
    endtask

    // stop sending and wait until every result is back and the pipe is empty
    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (expected_envelope.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int atk, input int sus, input int rel, input int len);
        wait_results();
        write_register(CFG_ATTACK_LENGTH,  CFG_DATA_BITS'(atk));
        write_register(CFG_SUSTAIN_ENABLE, CFG_DATA_BITS'(sus));
        write_register(CFG_RELEASE_LENGTH, CFG_DATA_BITS'(rel));
        write_register(CFG_TABLE_LENGTH,   CFG_DATA_BITS'(len));
        atk_len = ATK_BITS'(atk);
        sus_en  = sus[0];
        rel_len = REL_BITS'(rel);
        tbl_len = LEN_BITS'(len);
    endtask

    // result checking and receiver stalls
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_envelope.size() == 0) begin
                report_mismatch($sformatf("unexpected result level %0d phase %0d",
                                          o_out.level, o_out.phase));
            end else begin
                want = expected_envelope.pop_front();
                if (o_out.level !== want.level)
                    report_mismatch($sformatf("level %0d, predicted %0d",
                                              o_out.level, want.level));
                if (o_out.phase !== want.phase)
                    report_mismatch($sformatf("phase %0d, predicted %0d",
                                              o_out.phase, want.phase));
            end
        end
        i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_in_valid && o_in_ready) ||
            (o_out_valid === 1'b1 && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("table_adsr_envelope_player test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // field extremes and both button levels at the reset settings
    task automatic test_field_extremes();
        write_entry(0, 0);
        write_entry(DEPTH - 1, 4095);
        write_entry(341, 'hAAA);
        write_entry(682, 'h555);
        play_tick(1'b0);
        play_gesture(3, 2);
    endtask

    // full attack, sustain loop with wrap, and release tail
    task automatic test_envelope_cycle();
        configure(2, 1, 2, 8);
        play_gesture(8, 4);
    endtask

    task automatic test_special_cases();
        // release skipped with sustain disabled
        configure(2, 0, 2, 8);
        play_gesture(3, 2);
        // sustain region empty, keeps playing the entry after the attack
        configure(5, 1, 2, 6);
        play_gesture(9, 4);
        // zero table length, tail address below zero
        configure(0, 1, 3, 0);
        play_gesture(3, 5);
        // table length above the depth
        configure(1, 1, 1, 2047);
        play_gesture(4, 3);
        // button let go during attack
        configure(4, 1, 1, 16);
        play_gesture(2, 3);
    endtask

    // no idling on either side, then a pause until all results are back
    task automatic test_quiet_stretch();
        no_idle = 1'b1;
        configure(3, 1, 4, 20);
        repeat (6) play_gesture($urandom_range(1, 25), $urandom_range(1, 8));
        wait_results();
        no_idle = 1'b0;
    endtask

    task automatic test_random_envelopes();
        int atk, sus, rel, len, budget, roll, hold, fall;
        while (item_count < ITEMS_TARGET) begin
            roll = $urandom_range(99);
            if (roll < 20) begin
                // extremes
                atk = ($urandom_range(1)) ? 1023 : 0;
                rel = ($urandom_range(1)) ? 1023 : 0;
                case ($urandom_range(4))
                    0:       len = 0;
                    1:       len = 1;
                    2:       len = DEPTH;
                    3:       len = DEPTH + 1;
                    default: len = 2047;
                endcase
                sus = $urandom_range(1);
            end else if (roll < 30) begin
                // any register bit pattern
                atk = $urandom_range(2047);
                sus = $urandom_range(2047);
                rel = $urandom_range(2047);
                len = $urandom_range(2047);
            end else begin
                atk = $urandom_range(24);
                sus = ($urandom_range(3) != 0);
                rel = $urandom_range(12);
                len = $urandom_range(48);
            end
            configure(atk, sus, rel, len);
            budget = $urandom_range(20, 80);
            while (budget > 0) begin
                roll = $urandom_range(99);
                if (roll < 10) begin
                    write_entry($urandom_range(DEPTH - 1), $urandom_range(4095));
                    budget--;
                end else if (roll < 25) begin
                    play_tick(1'($urandom_range(1)));
                    budget--;
                end else begin
                    hold = $urandom_range(1, 30);
                    fall = $urandom_range(1, 10);
                    play_gesture(hold, fall);
                    budget -= hold + fall;
                end
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_ATTACK_LENGTH;
        i_cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_envelope_cycle();
        test_special_cases();
        test_quiet_stretch();
        test_random_envelopes();
        wait_results();
        if (mismatch_count == 0 && expected_envelope.size() == 0) begin
            $display("table_adsr_envelope_player test passed");
        end else begin
            $display("table_adsr_envelope_player test failed");
        end
        $finish;
    end

endmodule
